FILE: sv/stq_pkg.sv
package stq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int MAX_RESULTS = 16;

    localparam logic [31:0] HALF_RANGE    = 32'h7fffffff;
    localparam logic [31:0] SLEEP_FOREVER = 32'hFFFFFFFF;

    // Operation codes.
    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_ADD_REP = 3'd1;
    localparam logic [2:0] OP_CAN_HA  = 3'd2;
    localparam logic [2:0] OP_CAN_H   = 3'd3;
    localparam logic [2:0] OP_CHECK   = 3'd4;
    localparam logic [2:0] OP_RESTART = 3'd5;

    // Result kinds and status codes.
    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOMAT = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] now_time;
        logic [29:0] delay;
        logic [7:0]  handler_id;
        logic [15:0] arg_tag;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [7:0]  fired_handler;
        logic [15:0] fired_arg;
        logic [31:0] fired_due;
        logic [31:0] sleep_ticks;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [31:0] due;
        logic [7:0]  handler;
        logic [15:0] arg;
    } t_entry;

    // Source of the data written into the store.
    typedef enum logic [1:0] {
        WS_MOVE,
        WS_NEW,
        WS_REBASE
    } t_wsel;

    typedef struct packed {
        logic       ld_in;
        logic       rd_en;
        logic       we;
        t_wsel      wsel;
        logic       ld_base;
        logic       ld_sleep;
        logic       empty;
        logic       out_ld;
        logic [1:0] kind;
        logic [1:0] status;
        logic       fired;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic match_h;
        logic match_ha;
        logic new_earlier;
        logic expired;
        logic out_free;
    } t_stat;

    // a is earlier than b under wrap-around arithmetic.
    function automatic logic earlier(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d > HALF_RANGE;
    endfunction

endpackage

FILE: sv/stq_datapath.sv
module stq_datapath #(
    parameter int DEPTH = stq_pkg::DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  stq_pkg::t_in   i_in,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output stq_pkg::t_out  o_out,
    input  stq_pkg::t_cmd  i_cmd,
    input  logic [AW-1:0]  i_rd_addr,
    input  logic [AW-1:0]  i_wr_addr,
    output stq_pkg::t_stat o_stat
);

    stq_pkg::t_entry mem [DEPTH];
    stq_pkg::t_entry r_rd;
    stq_pkg::t_in    r_in;
    logic [31:0]     r_base;
    logic [31:0]     r_sleep;
    logic [31:0]     r_new_due;
    logic            r_out_valid;
    stq_pkg::t_out   r_out;

    stq_pkg::t_entry wdata;
    logic [31:0]     sleep_now;

    // Write data selection.
    always_comb begin
        wdata = r_rd;
        case (i_cmd.wsel)
            stq_pkg::WS_MOVE:   wdata = r_rd;
            stq_pkg::WS_NEW: begin
                wdata.due     = r_new_due;
                wdata.handler = r_in.handler_id;
                wdata.arg     = r_in.arg_tag;
            end
            stq_pkg::WS_REBASE: wdata.due = (r_rd.due - r_base) + r_in.now_time;
            default:            wdata = r_rd;
        endcase
    end

    // Sleep ticks from the entry just read.
    always_comb begin
        if (i_cmd.empty) begin
            sleep_now = stq_pkg::SLEEP_FOREVER;
        end else if (stq_pkg::earlier(r_rd.due, r_in.now_time)) begin
            sleep_now = 32'd0;
        end else begin
            sleep_now = r_rd.due - r_in.now_time;
        end
    end

    // Entry store with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            mem[i_wr_addr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[i_rd_addr];
        end
    end

    // Request and working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_in      <= i_in;
            r_new_due <= i_in.now_time + {2'b00, i_in.delay};
        end
        if (i_cmd.ld_base) begin
            r_base <= r_rd.due;
        end
        if (i_cmd.ld_sleep) begin
            r_sleep <= sleep_now;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_ld) begin
            r_out.kind          <= i_cmd.kind;
            r_out.status        <= i_cmd.status;
            r_out.fired_handler <= i_cmd.fired ? r_rd.handler : 8'd0;
            r_out.fired_arg     <= i_cmd.fired ? r_rd.arg : 16'd0;
            r_out.fired_due     <= i_cmd.fired ? r_rd.due : 32'd0;
            r_out.sleep_ticks   <= r_sleep;
            r_out.last          <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign o_stat.match_h     = (r_rd.handler == r_in.handler_id);
    assign o_stat.match_ha    = (r_rd.handler == r_in.handler_id) && (r_rd.arg == r_in.arg_tag);
    assign o_stat.new_earlier = stq_pkg::earlier(r_new_due, r_rd.due);
    assign o_stat.expired     = !stq_pkg::earlier(r_in.now_time, r_rd.due);
    assign o_stat.out_free    = !r_out_valid || !i_out_stall;

endmodule

FILE: sv/stq_ctrl.sv
module stq_ctrl #(
    parameter int DEPTH = stq_pkg::DEPTH_DEF,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [2:0]     i_op,
    output logic           o_stall,
    output stq_pkg::t_cmd  o_cmd,
    output logic [AW-1:0]  o_rd_addr,
    output logic [AW-1:0]  o_wr_addr,
    input  stq_pkg::t_stat i_stat
);

    typedef enum logic [4:0] {
        S_IDLE, S_CAN_RD, S_CAN_CMP, S_REM_RD, S_REM_WR, S_INS_START, S_INS_RD,
        S_INS_CMP, S_SH_RD, S_SH_WR, S_RST_RD0, S_RST_B, S_RW_RD, S_RW_WR,
        S_SLP_RD, S_SLP_CALC, S_SLP_OUT, S_CK_RD, S_CK_CMP, S_CK_SLP, S_CK_CALC,
        S_EM_RD, S_EM_OUT, S_CP_RD, S_CP_WR
    } t_state;

    t_state      r_state, n_state;
    logic [CW-1:0] r_idx, n_idx, r_pos, n_pos, r_k, n_k, r_cnt, n_cnt;
    logic [2:0]  r_op, n_op;
    logic [1:0]  r_status, n_status;
    logic [1:0]  r_kind, n_kind;
    logic [CW-1:0] rd_addr, wr_addr;

    logic cnt_full;
    assign cnt_full = (r_cnt == CW'(DEPTH));

    // Next state and commands.
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_k      = r_k;
        n_cnt    = r_cnt;
        n_op     = r_op;
        n_status = r_status;
        n_kind   = r_kind;
        o_cmd    = '0;
        o_cmd.wsel = stq_pkg::WS_MOVE;
        rd_addr  = r_idx;
        wr_addr  = r_idx;
        o_stall  = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.ld_in = 1'b1;
                    n_op     = i_op;
                    n_status = stq_pkg::ST_OK;
                    n_kind   = stq_pkg::KIND_ACK;
                    n_idx    = '0;
                    case (i_op)
                        stq_pkg::OP_ADD:     n_state = S_INS_START;
                        stq_pkg::OP_ADD_REP: n_state = S_CAN_RD;
                        stq_pkg::OP_CAN_HA:  n_state = S_CAN_RD;
                        stq_pkg::OP_CAN_H:   n_state = S_CAN_RD;
                        stq_pkg::OP_CHECK:   n_state = S_CK_RD;
                        stq_pkg::OP_RESTART: n_state = (r_cnt == '0) ? S_SLP_RD : S_RST_RD0;
                        default:             n_state = S_SLP_RD;
                    endcase
                end
            end
            // Search for the earliest matching entry.
            S_CAN_RD: begin
                if (r_idx < r_cnt) begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_CAN_CMP;
                end else if (r_op == stq_pkg::OP_ADD_REP) begin
                    n_state = S_INS_START;
                end else begin
                    n_status = stq_pkg::ST_NOMAT;
                    n_state  = S_SLP_RD;
                end
            end
            S_CAN_CMP: begin
                if ((r_op == stq_pkg::OP_CAN_HA) ? i_stat.match_ha : i_stat.match_h) begin
                    n_state = S_REM_RD;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_CAN_RD;
                end
            end
            // Close the gap left by the removed entry.
            S_REM_RD: begin
                if ((r_idx + CW'(1)) < r_cnt) begin
                    o_cmd.rd_en = 1'b1;
                    rd_addr = r_idx + CW'(1);
                    n_state = S_REM_WR;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                    n_idx = '0;
                    n_state = (r_op == stq_pkg::OP_ADD_REP) ? S_INS_START : S_SLP_RD;
                end
            end
            S_REM_WR: begin
                o_cmd.we = 1'b1;
                n_idx   = r_idx + CW'(1);
                n_state = S_REM_RD;
            end
            // Find the insertion point after all entries not later than the new one.
            S_INS_START: begin
                n_idx = '0;
                if (cnt_full) begin
                    n_status = stq_pkg::ST_FULL;
                    n_state  = S_SLP_RD;
                end else begin
                    n_state = S_INS_RD;
                end
            end
            S_INS_RD: begin
                if (r_idx < r_cnt) begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_INS_CMP;
                end else begin
                    n_pos   = r_idx;
                    n_idx   = r_cnt;
                    n_state = S_SH_RD;
                end
            end
            S_INS_CMP: begin
                if (i_stat.new_earlier) begin
                    n_pos   = r_idx;
                    n_idx   = r_cnt;
                    n_state = S_SH_RD;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_INS_RD;
                end
            end
            // Shift the tail up by one, then write the new entry.
            S_SH_RD: begin
                if (r_idx > r_pos) begin
                    o_cmd.rd_en = 1'b1;
                    rd_addr = r_idx - CW'(1);
                    n_state = S_SH_WR;
                end else begin
                    o_cmd.we   = 1'b1;
                    o_cmd.wsel = stq_pkg::WS_NEW;
                    wr_addr = r_pos;
                    n_cnt   = r_cnt + CW'(1);
                    n_state = S_SLP_RD;
                end
            end
            S_SH_WR: begin
                o_cmd.we = 1'b1;
                n_idx   = r_idx - CW'(1);
                n_state = S_SH_RD;
            end
            // Rebase all due times on the head.
            S_RST_RD0: begin
                o_cmd.rd_en = 1'b1;
                rd_addr = '0;
                n_state = S_RST_B;
            end
            S_RST_B: begin
                o_cmd.ld_base = 1'b1;
                n_idx   = '0;
                n_state = S_RW_RD;
            end
            S_RW_RD: begin
                if (r_idx < r_cnt) begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_RW_WR;
                end else begin
                    n_state = S_SLP_RD;
                end
            end
            S_RW_WR: begin
                o_cmd.we   = 1'b1;
                o_cmd.wsel = stq_pkg::WS_REBASE;
                n_idx   = r_idx + CW'(1);
                n_state = S_RW_RD;
            end
            // Single result with the sleep time of the head.
            S_SLP_RD: begin
                o_cmd.rd_en = 1'b1;
                rd_addr = '0;
                n_state = S_SLP_CALC;
            end
            S_SLP_CALC: begin
                o_cmd.ld_sleep = 1'b1;
                o_cmd.empty    = (r_cnt == '0);
                n_state = S_SLP_OUT;
            end
            S_SLP_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    o_cmd.kind   = r_kind;
                    o_cmd.status = r_status;
                    o_cmd.last   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            // Count the expired prefix.
            S_CK_RD: begin
                if ((r_idx < r_cnt) && (32'(r_idx) < stq_pkg::MAX_RESULTS)) begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_CK_CMP;
                end else begin
                    n_k     = r_idx;
                    n_state = S_CK_SLP;
                end
            end
            S_CK_CMP: begin
                if (i_stat.expired) begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_CK_RD;
                end else begin
                    n_k     = r_idx;
                    n_state = S_CK_SLP;
                end
            end
            S_CK_SLP: begin
                if (r_k == '0) begin
                    n_kind  = stq_pkg::KIND_NONE;
                    n_state = S_SLP_RD;
                end else begin
                    o_cmd.rd_en = (r_k < r_cnt);
                    rd_addr = r_k;
                    n_state = S_CK_CALC;
                end
            end
            S_CK_CALC: begin
                o_cmd.ld_sleep = 1'b1;
                o_cmd.empty    = (r_k >= r_cnt);
                n_idx   = '0;
                n_state = S_EM_RD;
            end
            // Report the expired entries in order.
            S_EM_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_EM_OUT;
            end
            S_EM_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    o_cmd.kind   = stq_pkg::KIND_EXPIRED;
                    o_cmd.status = stq_pkg::ST_OK;
                    o_cmd.fired  = 1'b1;
                    o_cmd.last   = ((r_idx + CW'(1)) == r_k);
                    if ((r_idx + CW'(1)) == r_k) begin
                        n_idx   = r_k;
                        n_state = S_CP_RD;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_EM_RD;
                    end
                end
            end
            // Move the remaining entries down to the head.
            S_CP_RD: begin
                if (r_idx < r_cnt) begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_CP_WR;
                end else begin
                    n_cnt   = r_cnt - r_k;
                    n_state = S_IDLE;
                end
            end
            S_CP_WR: begin
                o_cmd.we = 1'b1;
                wr_addr = r_idx - r_k;
                n_idx   = r_idx + CW'(1);
                n_state = S_CP_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_rd_addr = rd_addr[AW-1:0];
    assign o_wr_addr = wr_addr[AW-1:0];

    // State and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_pos    <= '0;
            r_k      <= '0;
            r_op     <= stq_pkg::OP_ADD;
            r_status <= stq_pkg::ST_OK;
            r_kind   <= stq_pkg::KIND_ACK;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_pos    <= n_pos;
            r_k      <= n_k;
            r_op     <= n_op;
            r_status <= n_status;
            r_kind   <= n_kind;
        end
    end

endmodule

FILE: sv/sorted_timeout_queue.sv
// Sorted timeout queue: holds up to DEPTH pending timeouts ordered by due time.
// Requests enter on i_valid/i_in and are accepted when i_valid is high and
// o_stall is low. Each request is add, add replacing a handler, cancel,
// check expired or restart, selected by the op field.
// Results leave on o_valid/o_out; the receiver holds i_stall high to stall.
// A check gives one result per expired entry (at most sixteen), last set on
// the final one, or one if none expired; other requests give exactly one.
// One request is worked at a time by a state machine that walks the entry
// store through a memory with one read and one write port. An add replacing
// a handler first removes the earliest entry of that handler, if any, and a
// check moves the entries that remain down to the head after it reports.
// The final result sits in an output register, so a new request is taken
// while it waits; a stalled receiver holds further results and the walk.
// After reset the store is empty; no clearing pass is needed.
module sorted_timeout_queue #(
    parameter int DEPTH = stq_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  stq_pkg::t_in  i_in,
    output logic          o_stall,
    output logic          o_valid,
    output stq_pkg::t_out o_out,
    input  logic          i_stall
);

    localparam int AW = $clog2(DEPTH);

    stq_pkg::t_cmd  cmd;
    stq_pkg::t_stat stat;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;

    stq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_op      (i_in.op),
        .o_stall   (o_stall),
        .o_cmd     (cmd),
        .o_rd_addr (rd_addr),
        .o_wr_addr (wr_addr),
        .i_stat    (stat)
    );

    stq_datapath #(.DEPTH(DEPTH)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_out       (o_out),
        .i_cmd       (cmd),
        .i_rd_addr   (rd_addr),
        .i_wr_addr   (wr_addr),
        .o_stat      (stat)
    );

endmodule
